[hdl/dq_pkg.sv]
// Package with the shared types and constants of the double-ended queue.
package dq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned CountW       = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic             en;
    op_e              op;
    logic [DataW-1:0] data;
  } cmd_t;

endpackage

[hdl/double_ended_queue.sv]
// Top level of the double-ended queue built as a row of shifting cells.
//
// The input channel (in_valid_i, in_ready_o) carries one operation per beat:
// push front, push back, pop front or pop back, with push_value_i used by
// pushes. The output channel (out_valid_o, out_ready_i) returns one beat per
// operation with the popped value, a status, the front and rear values, the
// entry count and an empty flag, all taken after the operation.
// The entries live in DEPTH cells; cell 0 holds the front. A push at the front
// or a pop at the front shifts the whole row by one cell, while a push at the
// back fills only the first free cell and a pop at the back clears only the
// last occupied cell. A result is held in the pending registers first and is
// then moved into the output register. One operation per cycle
// is sustained while the receiver keeps out_ready_i high; the rear value is
// an OR over all cells and sets the longest path.
// When the receiver stalls, the output register holds its beat and at most
// one more operation is executed and parked; then in_ready_o falls.
// Reset empties the queue and the output register; the cell contents are not
// cleared, as only occupied cells are ever read.
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DefaultDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                func_i,
  input  logic signed [31:0]        push_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [31:0]        popped_value_o,
  output logic [1:0]                status_o,
  output logic signed [31:0]        front_value_o,
  output logic signed [31:0]        rear_value_o,
  output logic [4:0]                entry_count_o,
  output logic                      is_empty_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     out_valid_q, out_valid_d;
  logic [dq_pkg::DataW-1:0] pend_popped_q, pend_popped_d;
  dq_pkg::status_e          pend_status_q, pend_status_d;

  logic [dq_pkg::DataW-1:0] popped_q, front_q, rear_q;
  dq_pkg::status_e          status_q;
  logic [CntW-1:0]          out_cnt_q;

  logic [DEPTH-1:0]                     cell_valid;
  logic [DEPTH-1:0][dq_pkg::DataW-1:0]  cell_value;
  logic [DEPTH-1:0][dq_pkg::DataW-1:0]  cell_tail;
  logic [dq_pkg::DataW-1:0]             rear_val, front_val;
  logic [CntW+4:0]                      cnt_wide;

  dq_pkg::op_e  op;
  dq_pkg::cmd_t cmd;
  logic         in_acc, is_push, full, empty, do_push, do_pop, out_free, snap;

  assign op       = dq_pkg::op_e'(func_i);
  assign in_acc   = in_valid_i && in_ready_o;
  assign is_push  = (op == dq_pkg::OP_PUSH_FRONT) || (op == dq_pkg::OP_PUSH_BACK);
  assign full     = (cnt_q == CntW'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign do_push  = is_push && !full;
  assign do_pop   = !is_push && !empty;
  assign out_free = !out_valid_q || out_ready_i;
  assign snap     = busy_q && out_free;
  assign in_ready_o = !busy_q || out_free;

  assign cmd.en   = in_acc && (do_push || do_pop);
  assign cmd.op   = op;
  assign cmd.data = push_value_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     lv, rv;
    logic [dq_pkg::DataW-1:0] lval, rval;
    if (i == 0) begin : g_first
      assign lv   = 1'b1;
      assign lval = push_value_i;
    end else begin : g_mid_l
      assign lv   = cell_valid[i-1];
      assign lval = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv   = 1'b0;
      assign rval = '0;
    end else begin : g_mid_r
      assign rv   = cell_valid[i+1];
      assign rval = cell_value[i+1];
    end
    dq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_valid_i (lv),
      .left_value_i (lval),
      .right_valid_i(rv),
      .right_value_i(rval),
      .valid_o      (cell_valid[i]),
      .value_o      (cell_value[i]),
      .tail_o       (cell_tail[i])
    );
  end

  always_comb begin
    rear_val = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      rear_val = rear_val | cell_tail[i];
    end
  end

  assign front_val = cell_valid[0] ? cell_value[0] : '0;

  always_comb begin
    cnt_d         = cnt_q;
    busy_d        = busy_q;
    pend_popped_d = pend_popped_q;
    pend_status_d = pend_status_q;
    if (snap) begin
      busy_d = 1'b0;
    end
    if (in_acc) begin
      busy_d = 1'b1;
      if (is_push) begin
        pend_popped_d = '0;
        pend_status_d = full ? dq_pkg::STAT_FULL : dq_pkg::STAT_DONE;
        if (!full) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end else if (empty) begin
        pend_popped_d = '1;
        pend_status_d = dq_pkg::STAT_EMPTY;
      end else begin
        pend_popped_d = (op == dq_pkg::OP_POP_FRONT) ? front_val : rear_val;
        pend_status_d = dq_pkg::STAT_DONE;
        cnt_d         = cnt_q - CntW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (snap) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_popped_q <= pend_popped_d;
    pend_status_q <= pend_status_d;
    if (snap) begin
      popped_q  <= pend_popped_q;
      status_q  <= pend_status_q;
      front_q   <= front_val;
      rear_q    <= rear_val;
      out_cnt_q <= cnt_q;
    end
  end

  assign cnt_wide       = {5'b0, out_cnt_q};
  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign front_value_o  = front_q;
  assign rear_value_o   = rear_q;
  assign entry_count_o  = cnt_wide[4:0];
  assign is_empty_o     = (out_cnt_q == '0);

`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(cnt_q))
    else $error("entry count differs from the number of occupied cells");

  a_front_cell_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == (cnt_q != '0))
    else $error("front cell occupancy disagrees with the entry count");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count exceeds the queue depth");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q)
    else $error("accepted beat left no pending result");

  a_snap_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap |=> out_valid_q)
    else $error("pending result was not moved to the output register");
`endif

endmodule

[hdl/dq_cell.sv]
// One storage cell of the queue, which shifts with its neighbors.
module dq_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dq_pkg::cmd_t             cmd_i,
  input  logic                     left_valid_i,
  input  logic [dq_pkg::DataW-1:0] left_value_i,
  input  logic                     right_valid_i,
  input  logic [dq_pkg::DataW-1:0] right_value_i,
  output logic                     valid_o,
  output logic [dq_pkg::DataW-1:0] value_o,
  output logic [dq_pkg::DataW-1:0] tail_o
);

  logic                     valid_q, valid_d;
  logic [dq_pkg::DataW-1:0] value_q, value_d;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.en) begin
      case (cmd_i.op)
        dq_pkg::OP_PUSH_FRONT: begin
          valid_d = left_valid_i;
          value_d = left_value_i;
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (!valid_q && left_valid_i) begin
            valid_d = 1'b1;
            value_d = cmd_i.data;
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          valid_d = right_valid_i;
          value_d = right_value_i;
        end
        default: begin
          if (valid_q && !right_valid_i) begin
            valid_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign tail_o  = (valid_q && !right_valid_i) ? value_q : '0;

endmodule
